// File: rtl/core/xtea_pkg.sv
// XTEA cipher package: request/result types, pipeline stage type,
// key storage type, cipher constants and the round mixing function.
// No dependencies; used by every file under rtl/core.
package xtea_pkg;

  localparam int unsigned ROUNDS_DEF = 32;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned KEY_WORDS = 4;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = CFG_INDEX_W'(3);

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  typedef struct packed {
    logic        func;
    logic [31:0] in_low_word;
    logic [31:0] in_high_word;
  } req_t;

  typedef struct packed {
    logic [31:0] out_low_word;
    logic [31:0] out_high_word;
  } res_t;

  // Payload carried from cell to cell
  typedef struct packed {
    logic        func;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
  } stage_t;

  function automatic logic [31:0] mix(input logic [31:0] v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// File: rtl/core/xtea_key_regs.sv
// XTEA key register file: four 32-bit key words written by index.
// Depends on xtea_pkg.
module xtea_key_regs
  import xtea_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   we,
  input  logic [CFG_INDEX_W-1:0] index,
  input  logic [31:0]            data,
  output key_t                   key
);

  // Store a key word; drop writes beyond the last register
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (we) begin
      unique case (index)
        REG_KEY_WORD0: key[0] <= data;
        REG_KEY_WORD1: key[1] <= data;
        REG_KEY_WORD2: key[2] <= data;
        REG_KEY_WORD3: key[3] <= data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/xtea_cell.sv
// XTEA half-round cell: one Feistel half-step in either direction,
// registered and handed to the next cell. Depends on xtea_pkg.
module xtea_cell
  import xtea_pkg::*;
#(
  parameter bit PHASE = 1'b0
) (
  input  logic   clk,
  input  logic   rst,
  input  key_t   key,
  input  logic   in_valid,
  input  stage_t in_stage,
  output logic   out_valid,
  output stage_t out_stage
);

  logic        upd_z;
  logic [1:0]  key_idx;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [31:0] f;
  logic [31:0] tgt_next;
  logic [31:0] sum_next;
  stage_t      stage_next;

  // Pick the half to update and the key word for this step
  always_comb begin
    upd_z    = in_stage.func ^ PHASE;
    key_idx  = upd_z ? in_stage.sum[12:11] : in_stage.sum[1:0];
    src      = upd_z ? in_stage.y : in_stage.z;
    tgt      = upd_z ? in_stage.z : in_stage.y;
    f        = mix(src) ^ (in_stage.sum + key[key_idx]);
    tgt_next = in_stage.func ? (tgt - f) : (tgt + f);
    if (PHASE == 1'b0) begin
      sum_next = in_stage.func ? (in_stage.sum - DELTA) : (in_stage.sum + DELTA);
    end else begin
      sum_next = in_stage.sum;
    end
    stage_next      = in_stage;
    stage_next.sum  = sum_next;
    if (upd_z) begin
      stage_next.z = tgt_next;
    end else begin
      stage_next.y = tgt_next;
    end
  end

  // Advance the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Hand the payload to the neighbor
  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule

// File: rtl/core/xtea_block_cipher_top.sv
// XTEA block cipher top level: key registers and a chain of half-round cells.
// Depends on xtea_pkg, xtea_key_regs and xtea_cell.
//
// Usage:
//   A request (func, in_low_word, in_high_word) is taken at a rising edge with
//   start high and busy low. busy is high only while rst is asserted, so one
//   request can be taken every cycle.
//   Each round is split into two cells, one per Feistel half, so the chain is
//   2*ROUNDS cells long; the per-cell path is one mixing add followed by the
//   final add or subtract. A request taken passes through every cell register
//   in order and gives its result on res with done high after the last cell,
//   one result per cycle sustained.
//   done lasts exactly one cycle per result; the receiver cannot stall, and
//   results leave in request order.
//   The key is written through the cfg channel (cfg_ready is always high);
//   index 0..3 selects key_word0..key_word3, other indexes are ignored.
//   Write the key only while no request is in flight.
//   Synchronous reset clears the key to zero and empties the cell chain.
module xtea_block_cipher_top
  import xtea_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  req_t                   req,
  output logic                   done,
  output res_t                   res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int unsigned CELLS = 2 * ROUNDS;
  localparam logic [31:0] SUM_DEC = 32'(64'(DELTA) * 64'(ROUNDS));

  key_t   key;
  logic   vld [0:CELLS];
  stage_t stage [0:CELLS];

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  xtea_key_regs u_key_regs (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .key   (key)
  );

  // Load the request into the head of the chain
  always_comb begin
    vld[0]       = start && !busy;
    stage[0].func = req.func;
    stage[0].y    = req.in_low_word;
    stage[0].z    = req.in_high_word;
    stage[0].sum  = req.func ? SUM_DEC : 32'h0;
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    xtea_cell #(
      .PHASE (1'(i % 2))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .in_valid  (vld[i]),
      .in_stage  (stage[i]),
      .out_valid (vld[i+1]),
      .out_stage (stage[i+1])
    );
  end

  // Drive the result from the last cell
  assign done              = vld[CELLS];
  assign res.out_low_word  = stage[CELLS].y;
  assign res.out_high_word = stage[CELLS].z;

`ifndef ASSERT_OFF
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, CELLS))
    else $error("result without a request taken 2*ROUNDS cycles earlier");

  a_sum_end : assert property (@(posedge clk) disable iff (rst)
    done |-> (stage[CELLS].sum == (stage[CELLS].func ? 32'h0 : SUM_DEC)))
    else $error("round sum at chain end does not match direction");

  a_func_kept : assert property (@(posedge clk) disable iff (rst)
    done |-> (stage[CELLS].func == $past(req.func, CELLS)))
    else $error("direction changed while passing through the chain");
`endif

endmodule
